FILE: src/spft_pkg.sv
// Shared types and constants for the sparse triplet fast transpose core.
package spft_pkg;

  localparam int MAX_DIM   = 32;
  localparam int MAX_TERMS = 64;

  localparam int DIM_W  = $clog2(MAX_DIM);     // column / row index width
  localparam int SLOT_W = $clog2(MAX_TERMS);   // store address width
  localparam int CNT_W  = SLOT_W + 1;          // counts up to MAX_TERMS
  localparam int VAL_W  = 32;
  localparam int NCOL_W = 6;                   // num_cols register width

  typedef struct packed {
    logic [DIM_W-1:0]        row;
    logic [DIM_W-1:0]        col;
    logic signed [VAL_W-1:0] val;
  } trip_t;

  typedef enum logic [2:0] {
    COL_NOP    = 3'd0,
    COL_COUNT  = 3'd1,
    COL_PREFIX = 3'd2,
    COL_TAKE   = 3'd3,
    COL_CLEAR  = 3'd4
  } col_op_t;

  typedef struct packed {
    col_op_t          op;
    logic [DIM_W-1:0] idx;
  } col_cmd_t;

endpackage

FILE: src/spft_col_unit.sv
// Column count / start slot table with one shared adder.
module spft_col_unit import spft_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  col_cmd_t         cmd,
  output logic [CNT_W-1:0] slot
);

  logic [CNT_W-1:0] counts    [MAX_DIM];
  logic [CNT_W-1:0] next_slot [MAX_DIM];
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] add_a;
  logic [CNT_W-1:0] add_b;
  logic [CNT_W-1:0] sum;
  logic [CNT_W-1:0] cnt_rd;
  logic [CNT_W-1:0] slot_rd;

  assign cnt_rd  = counts[cmd.idx];
  assign slot_rd = next_slot[cmd.idx];
  assign slot    = slot_rd;

  // One adder serves counting, the running prefix sum and slot advance.
  always_comb begin
    unique case (cmd.op)
      COL_COUNT: begin
        add_a = cnt_rd;
        add_b = CNT_W'(1);
      end
      COL_PREFIX: begin
        add_a = run;
        add_b = cnt_rd;
      end
      COL_TAKE: begin
        add_a = slot_rd;
        add_b = CNT_W'(1);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign sum = add_a + add_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        counts[i] <= '0;
      end
      run <= '0;
    end else begin
      unique case (cmd.op)
        COL_COUNT: begin
          counts[cmd.idx] <= sum;
        end
        COL_PREFIX: begin
          run <= sum;
        end
        COL_CLEAR: begin
          for (int i = 0; i < MAX_DIM; i++) begin
            counts[i] <= '0;
          end
          run <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Start slots carry no reset; every entry is written by the prefix pass.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      COL_PREFIX: next_slot[cmd.idx] <= run;
      COL_TAKE:   next_slot[cmd.idx] <= sum;
      default: begin
      end
    endcase
  end

endmodule

FILE: src/sparse_triplet_fast_transpose_core.sv
// Top level of the sparse triplet fast transpose core.
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ---------------------------------------------
//  in       in_valid / in_ready     has_entry, src_row, src_col, entry_value,
//                                   last_entry
//  out      out_valid / out_ready   out_row, out_col, out_value, out_last, overflow
//  cfg      cfg_write               cfg_data (num_cols)
//
// Loading takes one transaction per cycle. A last transaction stops intake for
// the prefix pass over all MAX_DIM columns, the scatter pass over the n stored
// entries, a store read state and an output state for each result and a clearing state.
// The store read ports and the shared adder of the column table set these phases.
// Reset is synchronous; no clearing pass is needed after it. A stalled result
// holds its output register until out_ready is seen.
module sparse_triplet_fast_transpose_core import spft_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    has_entry,
  input  logic [DIM_W-1:0]        src_row,
  input  logic [DIM_W-1:0]        src_col,
  input  logic signed [VAL_W-1:0] entry_value,
  input  logic                    last_entry,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DIM_W-1:0]        out_row,
  output logic [DIM_W-1:0]        out_col,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last,
  output logic                    overflow,
  input  logic                    cfg_write,
  input  logic [NCOL_W-1:0]       cfg_data
);

  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,
    S_PREFIX  = 6'b000010,
    S_SCAT    = 6'b000100,
    S_EMIT_RD = 6'b001000,
    S_EMIT    = 6'b010000,
    S_CLEAR   = 6'b100000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [NCOL_W-1:0] num_cols;
  logic [CNT_W-1:0]  term_count;
  logic [CNT_W-1:0]  step;
  logic [CNT_W-1:0]  step_inc;
  logic              ovf_flag;
  logic              rd_valid;

  trip_t triplet_store    [MAX_TERMS];
  trip_t transposed_store [MAX_TERMS];
  trip_t trip_q;
  trip_t tr_q;
  trip_t tr_wr;

  col_cmd_t         col_cmd;
  logic [CNT_W-1:0] col_slot;

  logic in_acc;
  logic out_acc;
  logic entry_ok;
  logic issue;
  logic emit_last;

  spft_col_unit u_col (
    .clk  (clk),
    .rst  (rst),
    .cmd  (col_cmd),
    .slot (col_slot)
  );

  assign in_ready  = (state == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state == S_EMIT);
  assign out_acc   = out_valid && out_ready;
  assign step_inc  = step + CNT_W'(1);

  // The column must be below num_cols (which may exceed MAX_DIM) and a slot free.
  assign entry_ok = has_entry && ({1'b0, src_col} < num_cols)
                    && (term_count < CNT_W'(MAX_TERMS));
  assign issue     = (state == S_SCAT) && (step < term_count);
  assign emit_last = (step_inc == term_count);

  // Swap row and column on the way into the transposed store.
  assign tr_wr = '{row: trip_q.col, col: trip_q.row, val: trip_q.val};

  // Column table command for the current cycle.
  always_comb begin
    col_cmd.op  = COL_NOP;
    col_cmd.idx = step[DIM_W-1:0];
    unique case (state)
      S_LOAD: begin
        col_cmd.idx = src_col;
        if (in_acc && entry_ok) begin
          col_cmd.op = COL_COUNT;
        end
      end
      S_PREFIX: begin
        col_cmd.op = COL_PREFIX;
      end
      S_SCAT: begin
        col_cmd.idx = trip_q.col;
        if (rd_valid) begin
          col_cmd.op = COL_TAKE;
        end
      end
      S_CLEAR: begin
        col_cmd.op = COL_CLEAR;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_acc && last_entry) begin
          state_next = S_PREFIX;
        end
      end
      S_PREFIX: begin
        if (step[DIM_W-1:0] == DIM_W'(MAX_DIM - 1)) begin
          state_next = (term_count == '0) ? S_CLEAR : S_SCAT;
        end
      end
      S_SCAT: begin
        if (!issue && !rd_valid) begin
          state_next = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          state_next = emit_last ? S_CLEAR : S_EMIT_RD;
        end
      end
      S_CLEAR: begin
        state_next = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  function automatic logic [CNT_W-1:0] step_inc_tc(input logic [CNT_W-1:0] v);
    return v + CNT_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      num_cols   <= NCOL_W'(MAX_DIM);
      term_count <= '0;
      step       <= '0;
      ovf_flag   <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (cfg_write) begin
        num_cols <= cfg_data;
      end
      unique case (state)
        S_LOAD: begin
          step <= '0;
          if (in_acc && has_entry) begin
            if (entry_ok) begin
              term_count <= step_inc_tc(term_count);
            end else begin
              ovf_flag <= 1'b1;
            end
          end
        end
        S_PREFIX: begin
          // Leave the counter at zero for the scatter pass.
          step <= (state_next == S_PREFIX) ? step_inc : '0;
        end
        S_SCAT: begin
          if (issue) begin
            step <= step_inc;
          end else if (!rd_valid) begin
            step <= '0;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            step <= step_inc;
          end
        end
        S_CLEAR: begin
          term_count <= '0;
          ovf_flag   <= 1'b0;
          step       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Source triplet store: written while loading, read in order while scattering.
  always_ff @(posedge clk) begin
    if (in_acc && entry_ok) begin
      triplet_store[term_count[SLOT_W-1:0]] <= '{row: src_row, col: src_col,
                                                 val: entry_value};
    end
    if (issue) begin
      trip_q <= triplet_store[step[SLOT_W-1:0]];
    end
  end

  // Transposed store: scattered to the column's next slot, read out in order.
  always_ff @(posedge clk) begin
    if ((state == S_SCAT) && rd_valid) begin
      transposed_store[col_slot[SLOT_W-1:0]] <= tr_wr;
    end
    if (state == S_EMIT_RD) begin
      tr_q <= transposed_store[step[SLOT_W-1:0]];
    end
  end

  assign out_row   = tr_q.row;
  assign out_col   = tr_q.col;
  assign out_value = tr_q.val;
  assign out_last  = emit_last;
  assign overflow  = ovf_flag;

endmodule
